// ===== rtl/lpi_pkg.sv =====
// shared widths, types and register codes for the line/plane intersection block
// no dependencies
package lpi_pkg;

    localparam int COORD_W = 16;
    localparam int PT_W    = 3 * COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int COEF_W  = 2 * DIFF_W + 1;
    localparam int TERM_W  = COEF_W + DIFF_W;
    localparam int NUM_W   = TERM_W + 2;
    localparam int DTERM_W = COEF_W + COORD_W;
    localparam int DEN_W   = DTERM_W + 2;
    localparam int PROD_W  = NUM_W + COORD_W;
    localparam int SPLIT_W = NUM_W / 2;
    localparam int QUO_W   = COORD_W + 2;
    localparam int WORK_W  = ((PROD_W + 1 > DEN_W + QUO_W + 1) ?
                              (PROD_W + 1) : (DEN_W + QUO_W + 1)) + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_C = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic signed [DEN_W-1:0]   den_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec_t;

    typedef struct packed {
        coef_t a;
        coef_t b;
        coef_t c;
    } normal_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic ovf;
    } ctl_t;

endpackage

// ===== rtl/lpi_plane.sv =====
// plane normal from the three configured points, two register stages
// depends on lpi_pkg
module lpi_plane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpi_pkg::vec_t         p1,
    input  lpi_pkg::vec_t         p2,
    input  lpi_pkg::vec_t         p3,
    output lpi_pkg::normal_t      normal
);
    import lpi_pkg::*;

    logic signed [DIFF_W-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    normal_t normal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ux_reg     <= '0;
            uy_reg     <= '0;
            uz_reg     <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            vz_reg     <= '0;
            normal_reg <= '0;
        end
        else
        begin
            ux_reg <= DIFF_W'(p2.x) - DIFF_W'(p1.x);
            uy_reg <= DIFF_W'(p2.y) - DIFF_W'(p1.y);
            uz_reg <= DIFF_W'(p2.z) - DIFF_W'(p1.z);
            vx_reg <= DIFF_W'(p3.x) - DIFF_W'(p1.x);
            vy_reg <= DIFF_W'(p3.y) - DIFF_W'(p1.y);
            vz_reg <= DIFF_W'(p3.z) - DIFF_W'(p1.z);
            // cross product (p2 - p1) x (p3 - p1)
            normal_reg.a <= COEF_W'(uy_reg) * COEF_W'(vz_reg) - COEF_W'(uz_reg) * COEF_W'(vy_reg);
            normal_reg.b <= COEF_W'(uz_reg) * COEF_W'(vx_reg) - COEF_W'(ux_reg) * COEF_W'(vz_reg);
            normal_reg.c <= COEF_W'(ux_reg) * COEF_W'(vy_reg) - COEF_W'(uy_reg) * COEF_W'(vx_reg);
        end
    end

    assign normal = normal_reg;

endmodule

// ===== rtl/lpi_front.sv =====
// front pipeline: numerator and denominator of the line parameter, four stages
// depends on lpi_pkg
module lpi_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_v,
    input  lpi_pkg::vec_t         origin,
    input  lpi_pkg::vec_t         dir,
    input  lpi_pkg::vec_t         p1,
    input  lpi_pkg::normal_t      normal,
    output logic                  out_v,
    output lpi_pkg::vec_t         out_origin,
    output lpi_pkg::vec_t         out_dir,
    output lpi_pkg::num_t         num,
    output lpi_pkg::den_t         den
);
    import lpi_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    vec_t o1_reg, o2_reg, o3_reg, o4_reg;
    vec_t d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [DIFF_W-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [TERM_W-1:0] ta_reg, tb_reg, tc_reg;
    logic signed [DTERM_W-1:0] da_reg, db_reg, dc_reg;
    num_t num_reg;
    den_t den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o1_reg <= origin;
            d1_reg <= dir;
            // origin relative to the first plane point
            rx_reg <= DIFF_W'(o1_reg.x) - DIFF_W'(p1.x);
            ry_reg <= DIFF_W'(o1_reg.y) - DIFF_W'(p1.y);
            rz_reg <= DIFF_W'(o1_reg.z) - DIFF_W'(p1.z);
            o2_reg <= o1_reg;
            d2_reg <= d1_reg;
            ta_reg <= TERM_W'(normal.a) * TERM_W'(rx_reg);
            tb_reg <= TERM_W'(normal.b) * TERM_W'(ry_reg);
            tc_reg <= TERM_W'(normal.c) * TERM_W'(rz_reg);
            da_reg <= DTERM_W'(normal.a) * DTERM_W'(d2_reg.x);
            db_reg <= DTERM_W'(normal.b) * DTERM_W'(d2_reg.y);
            dc_reg <= DTERM_W'(normal.c) * DTERM_W'(d2_reg.z);
            o3_reg <= o2_reg;
            d3_reg <= d2_reg;
            num_reg <= -(NUM_W'(ta_reg) + NUM_W'(tb_reg) + NUM_W'(tc_reg));
            den_reg <= DEN_W'(da_reg) + DEN_W'(db_reg) + DEN_W'(dc_reg);
            o4_reg <= o3_reg;
            d4_reg <= d3_reg;
        end
    end

    assign out_v      = v4_reg;
    assign out_origin = o4_reg;
    assign out_dir    = d4_reg;
    assign num        = num_reg;
    assign den        = den_reg;

endmodule

// ===== rtl/lpi_div.sv =====
// one axis: dir*num, rounded restoring division by den, add origin, saturate
// depends on lpi_pkg
module lpi_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_v,
    input  lpi_pkg::coord_t       origin,
    input  lpi_pkg::coord_t       dir,
    input  lpi_pkg::num_t         num,
    input  lpi_pkg::den_t         den,
    output lpi_pkg::ctl_t         ctl,
    output lpi_pkg::coord_t       res
);
    import lpi_pkg::*;

    localparam int HI_W  = NUM_W - SPLIT_W;
    localparam int PLO_W = COORD_W + SPLIT_W + 1;
    localparam int PHI_W = COORD_W + HI_W;
    localparam int SUM_W = QUO_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_MAX =
        $signed({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    // head stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic h1_reg, h2_reg, h3_reg, h4_reg, h5_reg;
    coord_t o1_reg, o2_reg, o3_reg, o4_reg, o5_reg;
    logic signed [PLO_W-1:0] plo_reg;
    logic signed [PHI_W-1:0] phi_reg;
    den_t den1_reg, den2_reg;
    logic signed [PROD_W-1:0] n_reg;
    logic neg3_reg, neg4_reg, neg5_reg;
    logic [PROD_W-1:0] an_reg;
    logic [DEN_W-1:0] ad_reg;
    logic [WORK_W-1:0] np_reg, dp4_reg;
    logic [WORK_W-1:0] np5_reg, dp5_reg;
    logic big5_reg;

    // division steps, one quotient bit per stage
    logic              sv_reg   [QUO_W+1];
    logic              sh_reg   [QUO_W+1];
    logic              sneg_reg [QUO_W+1];
    logic              sbig_reg [QUO_W+1];
    coord_t            so_reg   [QUO_W+1];
    logic [WORK_W-1:0] rem_reg  [QUO_W+1];
    logic [WORK_W-1:0] dp_reg   [QUO_W+1];
    logic [QUO_W-1:0]  q_reg    [QUO_W+1];

    // tail
    logic f1v_reg, f1h_reg, f2v_reg, f2h_reg, ovf_reg;
    coord_t f1o_reg, res_reg;
    logic signed [QUO_W:0] qs_reg;

    logic [QUO_W-1:0] qmag;
    logic signed [SUM_W-1:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            f1v_reg <= 1'b0;
            f2v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= in_v;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            f1v_reg <= sv_reg[QUO_W];
            f2v_reg <= f1v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // split product keeps each multiplier narrow
            plo_reg  <= PLO_W'(dir) * $signed({1'b0, num[SPLIT_W-1:0]});
            phi_reg  <= PHI_W'(dir) * PHI_W'($signed(num[NUM_W-1:SPLIT_W]));
            h1_reg   <= den != '0;
            den1_reg <= den;
            o1_reg   <= origin;

            n_reg    <= (PROD_W'(phi_reg) <<< SPLIT_W) + PROD_W'(plo_reg);
            den2_reg <= den1_reg;
            h2_reg   <= h1_reg;
            o2_reg   <= o1_reg;

            neg3_reg <= n_reg[PROD_W-1] ^ den2_reg[DEN_W-1];
            an_reg   <= n_reg[PROD_W-1] ? PROD_W'(-n_reg) : PROD_W'(n_reg);
            ad_reg   <= den2_reg[DEN_W-1] ? DEN_W'(-den2_reg) : DEN_W'(den2_reg);
            h3_reg   <= h2_reg;
            o3_reg   <= o2_reg;

            // round half away from zero: (2|n| + |d|) / (2|d|)
            np_reg   <= (WORK_W'(an_reg) << 1) + WORK_W'(ad_reg);
            dp4_reg  <= WORK_W'(ad_reg) << 1;
            neg4_reg <= neg3_reg;
            h4_reg   <= h3_reg;
            o4_reg   <= o3_reg;

            // quotient too large for any in-range result
            big5_reg <= np_reg >= (dp4_reg << QUO_W);
            np5_reg  <= np_reg;
            dp5_reg  <= dp4_reg;
            neg5_reg <= neg4_reg;
            h5_reg   <= h4_reg;
            o5_reg   <= o4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg[0]   <= h5_reg;
            sneg_reg[0] <= neg5_reg;
            sbig_reg[0] <= big5_reg;
            so_reg[0]   <= o5_reg;
            rem_reg[0]  <= np5_reg;
            dp_reg[0]   <= dp5_reg;
            q_reg[0]    <= '0;
        end
    end

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_step
        localparam int SHIFT = QUO_W - 1 - j;
        logic [WORK_W-1:0] trial;
        logic              take;

        assign trial = dp_reg[j] << SHIFT;
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sh_reg[j+1]   <= sh_reg[j];
                sneg_reg[j+1] <= sneg_reg[j];
                sbig_reg[j+1] <= sbig_reg[j];
                so_reg[j+1]   <= so_reg[j];
                dp_reg[j+1]   <= dp_reg[j];
                rem_reg[j+1]  <= take ? (rem_reg[j] - trial) : rem_reg[j];
                q_reg[j+1]    <= {q_reg[j][QUO_W-2:0], take};
            end
        end
    end

    // an all-ones magnitude still lands outside the range, so it saturates alike
    assign qmag = sbig_reg[QUO_W] ? '1 : q_reg[QUO_W];
    assign sum  = SUM_W'(f1o_reg) + SUM_W'(qs_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qs_reg  <= sneg_reg[QUO_W] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
            f1h_reg <= sh_reg[QUO_W];
            f1o_reg <= so_reg[QUO_W];

            f2h_reg <= f1h_reg;
            if (!f1h_reg)
            begin
                res_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (sum > SAT_MAX)
            begin
                res_reg <= COORD_W'(SAT_MAX);
                ovf_reg <= 1'b1;
            end
            else if (sum < SAT_MIN)
            begin
                res_reg <= COORD_W'(SAT_MIN);
                ovf_reg <= 1'b1;
            end
            else
            begin
                res_reg <= COORD_W'(sum);
                ovf_reg <= 1'b0;
            end
        end
    end

    assign ctl.valid = f2v_reg;
    assign ctl.hit   = f2h_reg;
    assign ctl.ovf   = ovf_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/line_plane_intersection.sv =====
// line_plane_intersection: top level, configuration registers and stall control
// depends on lpi_pkg, lpi_plane, lpi_front, lpi_div
//
// A plane is set by three points written on the configuration channel
// (cfg_index 0..2, cfg_data packs x, y, z as signed Q8.8, x in the low bits);
// writes to other indexes are dropped and cfg_ready is always high.
// Each request on the input channel is a line (origin and direction); each
// produces exactly one result: hit, the intersection point and an overflow
// flag for coordinates that were clamped. No hit gives all-zero fields.
// Once accepted, a request reaches out_valid through the front, head, division
// and tail stages; one request is taken per cycle unless the pipeline holds.
// The pipeline is split multipliers followed by a restoring divider with one quotient bit per stage.
// After a write, the plane feeds the pipeline through the plane module's difference and normal registers.
// Reset clears the plane points and empties the pipeline.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated.
module line_plane_intersection (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpi_pkg::PT_W-1:0]       cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  lpi_pkg::coord_t                origin_x,
    input  lpi_pkg::coord_t                origin_y,
    input  lpi_pkg::coord_t                origin_z,
    input  lpi_pkg::coord_t                dir_x,
    input  lpi_pkg::coord_t                dir_y,
    input  lpi_pkg::coord_t                dir_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output lpi_pkg::coord_t                hit_x,
    output lpi_pkg::coord_t                hit_y,
    output lpi_pkg::coord_t                hit_z,
    output logic                           overflow
);
    import lpi_pkg::*;

    vec_t pa_reg, pb_reg, pc_reg;
    normal_t normal;
    logic en;
    logic front_v;
    vec_t front_o, front_d;
    num_t num;
    den_t den;
    ctl_t ctl_x, ctl_y, ctl_z;
    vec_t origin, dir;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg <= '0;
            pb_reg <= '0;
            pc_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POINT_A: pa_reg <= cfg_data;
                CFG_POINT_B: pb_reg <= cfg_data;
                CFG_POINT_C: pc_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // global hold while a result waits
    assign en       = !ctl_x.valid || out_ready;
    assign in_ready = en;

    assign origin = '{z: origin_z, y: origin_y, x: origin_x};
    assign dir    = '{z: dir_z, y: dir_y, x: dir_x};

    lpi_plane u_plane (
        .clk    (clk),
        .rst_n  (rst_n),
        .p1     (pa_reg),
        .p2     (pb_reg),
        .p3     (pc_reg),
        .normal (normal)
    );

    lpi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_v       (in_valid),
        .origin     (origin),
        .dir        (dir),
        .p1         (pa_reg),
        .normal     (normal),
        .out_v      (front_v),
        .out_origin (front_o),
        .out_dir    (front_d),
        .num        (num),
        .den        (den)
    );

    lpi_div u_div_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (front_v),
        .origin (front_o.x),
        .dir    (front_d.x),
        .num    (num),
        .den    (den),
        .ctl    (ctl_x),
        .res    (hit_x)
    );

    lpi_div u_div_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (front_v),
        .origin (front_o.y),
        .dir    (front_d.y),
        .num    (num),
        .den    (den),
        .ctl    (ctl_y),
        .res    (hit_y)
    );

    lpi_div u_div_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_v   (front_v),
        .origin (front_o.z),
        .dir    (front_d.z),
        .num    (num),
        .den    (den),
        .ctl    (ctl_z),
        .res    (hit_z)
    );

    assign out_valid = ctl_x.valid & ctl_y.valid & ctl_z.valid;
    assign hit       = ctl_x.hit;
    assign overflow  = ctl_x.ovf | ctl_y.ovf | ctl_z.ovf;

endmodule

// ===== tb/line_plane_intersection_tb.sv =====
// self-checking testbench for line_plane_intersection: planes and line requests
// depends on lpi_pkg and the line_plane_intersection rtl
module line_plane_intersection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpi_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic   hit;
        coord_t x;
        coord_t y;
        coord_t z;
        logic   ovf;
    } isect_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PT_W-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    coord_t               origin_x, origin_y, origin_z;
    coord_t               dir_x, dir_y, dir_z;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;
    coord_t               hit_x, hit_y, hit_z;
    logic                 overflow;

    // plane as the testbench believes it is configured
    logic [PT_W-1:0] plane_pt [3];
    isect_t          pending_isects[$];
    int              send_idle_pct;
    int              recv_stall_pct;
    int              n_failures;
    int              n_lines;
    int              n_hits;
    int              n_clamped;

    line_plane_intersection u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic wide_t ext(coord_t v);
        return wide_t'(v);
    endfunction

    function automatic wide_t pt_coord(int p, int k);
        coord_t v;
        v = plane_pt[p][k*COORD_W +: COORD_W];
        return ext(v);
    endfunction

    function automatic coord_t clamp_coord(wide_t s, ref logic ovf);
        if (s > wide_t'(32767))
        begin
            ovf = 1'b1;
            return 16'sh7fff;
        end
        if (s < -wide_t'(32768))
        begin
            ovf = 1'b1;
            return 16'sh8000;
        end
        return coord_t'(s[COORD_W-1:0]);
    endfunction

    function automatic isect_t intersect_line(coord_t ox, coord_t oy, coord_t oz,
                                              coord_t dx, coord_t dy, coord_t dz);
        wide_t  x1, y1, z1, x2, y2, z2, x3, y3, z3;
        wide_t  a, b, c, d, den, num, prod, an, ad, q;
        wide_t  o[3];
        wide_t  dv[3];
        coord_t pt[3];
        logic   ovf;
        isect_t r;
        x1 = pt_coord(0, 0); y1 = pt_coord(0, 1); z1 = pt_coord(0, 2);
        x2 = pt_coord(1, 0); y2 = pt_coord(1, 1); z2 = pt_coord(1, 2);
        x3 = pt_coord(2, 0); y3 = pt_coord(2, 1); z3 = pt_coord(2, 2);
        o[0] = ext(ox); o[1] = ext(oy); o[2] = ext(oz);
        dv[0] = ext(dx); dv[1] = ext(dy); dv[2] = ext(dz);
        a = y1*(z2-z3) + y2*(z3-z1) + y3*(z1-z2);
        b = z1*(x2-x3) + z2*(x3-x1) + z3*(x1-x2);
        c = x1*(y2-y3) + x2*(y3-y1) + x3*(y1-y2);
        d = -(x1*(y2*z3-y3*z2) + x2*(y3*z1-y1*z3) + x3*(y1*z2-y2*z1));
        den = a*dv[0] + b*dv[1] + c*dv[2];
        r = '{1'b0, '0, '0, '0, 1'b0};
        if (den == 0)
            return r;
        num = -(a*o[0] + b*o[1] + c*o[2] + d);
        ovf = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            prod = dv[i] * num;
            an = (prod < 0) ? -prod : prod;
            ad = (den < 0) ? -den : den;
            // nearest, ties away from zero
            q = (2*an + ad) / (2*ad);
            if ((prod < 0) != (den < 0))
                q = -q;
            pt[i] = clamp_coord(o[i] + q, ovf);
        end
        r = '{1'b1, pt[0], pt[1], pt[2], ovf};
        return r;
    endfunction

    task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [PT_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_POINT_A || idx == CFG_POINT_B || idx == CFG_POINT_C)
            plane_pt[idx] = data;
        cfg_valid <= 1'b0;
        // wait until the plane has passed the plane module's registers
        repeat (3) @(posedge clk);
    endtask

    task automatic set_plane(logic [PT_W-1:0] pa, logic [PT_W-1:0] pb, logic [PT_W-1:0] pc);
        write_plane(CFG_POINT_A, pa);
        write_plane(CFG_POINT_B, pb);
        write_plane(CFG_POINT_C, pc);
    endtask

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_line(coord_t ox, coord_t oy, coord_t oz,
                             coord_t dx, coord_t dy, coord_t dz);
        isect_t e;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        origin_x <= ox; origin_y <= oy; origin_z <= oz;
        dir_x <= dx; dir_y <= dy; dir_z <= dz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        e = intersect_line(ox, oy, oz, dx, dy, dz);
        pending_isects.push_back(e);
        n_lines++;
        if (e.hit)
            n_hits++;
        if (e.ovf)
            n_clamped++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_isects.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // response check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_isects.size() == 0)
                begin
                    $error("result with no request outstanding");
                    n_failures++;
                end
                else
                begin
                    isect_t e;
                    e = pending_isects.pop_front();
                    if (hit !== e.hit)
                    begin
                        $error("hit: expected %0d actual %0d", e.hit, hit);
                        n_failures++;
                    end
                    if (hit_x !== e.x)
                    begin
                        $error("hit_x: expected %0d actual %0d", e.x, hit_x);
                        n_failures++;
                    end
                    if (hit_y !== e.y)
                    begin
                        $error("hit_y: expected %0d actual %0d", e.y, hit_y);
                        n_failures++;
                    end
                    if (hit_z !== e.z)
                    begin
                        $error("hit_z: expected %0d actual %0d", e.z, hit_z);
                        n_failures++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $error("overflow: expected %0d actual %0d", e.ovf, overflow);
                        n_failures++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [PT_W-1:0] pack_pt(coord_t x, coord_t y, coord_t z);
        return {z, y, x};
    endfunction

    function automatic coord_t rand_coord();
        // mostly modest values so lines land inside range, some full scale
        if ($urandom_range(3) == 0)
            return coord_t'($urandom);
        return coord_t'($urandom_range(4096) - 2048);
    endfunction

    task automatic test_directed();
        // tilted plane through (1,0,0), (0,1,0), (0,0,1) in Q8.8
        set_plane(pack_pt(16'sd256, 0, 0), pack_pt(0, 16'sd256, 0), pack_pt(0, 0, 16'sd256));
        send_line(0, 0, 0, 16'sd256, 16'sd256, 16'sd256);
        send_line(0, 0, 0, 0, 0, 0);
        send_line(0, 0, 0, 16'sd256, -16'sd256, 0);
        send_line(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_line(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_line(16'sh8000, 16'sh7fff, 0, 16'sd1, 16'sd1, 16'sd1);
        send_line(0, 0, 0, 16'sd1, 16'sh7fff, 16'sh8000);
        send_line(16'sd3, 16'sd5, 16'sd7, 16'sd3, 16'sd0, 16'sd0);
        send_line(16'sh7fff, 0, 0, -16'sd1, 16'sh7fff, 16'sh7fff);
        drain();
        // extreme plane points
        set_plane(pack_pt(16'sh7fff, 16'sh8000, 16'sh7fff),
                  pack_pt(16'sh8000, 16'sh7fff, 16'sh8000),
                  pack_pt(16'sh7fff, 16'sh7fff, 16'sh8000));
        send_line(0, 0, 0, 16'sd256, 16'sd256, 16'sd256);
        send_line(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd1);
        send_line(16'sd1, -16'sd1, 16'sd1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        drain();
        // collinear points: no plane, never a hit
        set_plane(pack_pt(0, 0, 0), pack_pt(16'sd256, 16'sd256, 16'sd256),
                  pack_pt(16'sd512, 16'sd512, 16'sd512));
        send_line(0, 0, 0, 16'sd256, 0, 0);
        send_line(16'sh7fff, 16'sh8000, 0, 16'sh8000, 16'sh7fff, 16'sd9);
        drain();
        // index above the point registers must be dropped
        write_plane(2'd3, pack_pt(16'sd100, 16'sd200, 16'sd300));
        send_line(0, 16'sd10, 0, 16'sd5, 16'sd7, 16'sd11);
        // plane z = 0
        drain();
        set_plane(pack_pt(0, 0, 0), pack_pt(16'sd256, 0, 0), pack_pt(0, 16'sd256, 0));
        send_line(16'sd100, -16'sd100, 16'sd512, 16'sd3, 16'sd5, -16'sd256);
        send_line(16'sd100, -16'sd100, 16'sd512, 16'sd3, 16'sd5, 16'sd0);
        send_line(0, 0, 16'sd1, 16'sd1, 16'sd1, 16'sd3);
        drain();
        // point registers back to reset value
        set_plane('0, '0, '0);
        send_line(16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        logic [PT_W-1:0] p [3];
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < 3; i++)
            p[i] = pack_pt(rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(4) == 0)
            p[$urandom_range(2)] = PT_W'({$urandom, $urandom});
        set_plane(p[0], p[1], p[2]);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                // reconfigure halfway through
                drain();
                set_plane(pack_pt(rand_coord(), rand_coord(), rand_coord()),
                          pack_pt(rand_coord(), rand_coord(), rand_coord()),
                          pack_pt(rand_coord(), rand_coord(), rand_coord()));
            end
            send_line(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        out_ready = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_failures = 0;
        n_lines = 0;
        n_hits = 0;
        n_clamped = 0;
        for (int i = 0; i < 3; i++)
            plane_pt[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_phase(0, 0, 110);
        test_random_phase(76, 0, 110);
        test_random_phase(0, 76, 110);
        test_random_phase(27, 27, 110);

        $display("checked %0d line requests, %0d hits, %0d clamped, over 4 flow phases",
                 n_lines, n_hits, n_clamped);
        if (n_failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
